FILE: design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared definitions for the LRU key-value store
// Sizes of the store, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int RANK_W      = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int LIMIT_W     = 5;
  localparam int LIMIT_RESET = 16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_ADD = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_LAST   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FINISH = 5'b10000
  } lkv_state_t;

endpackage

FILE: design/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

FILE: design/lru_key_value_store_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_store_unit: fully associative key-value store, LRU replacement
// Each request beat is a get or an add; each gives exactly one result beat.
// ----------------------------------------------------------------------------
// Input channel in_*: one request per beat, opcode in in_tuser, key and new
// value in in_tdata. Result channel out_*: hit and evicted flags in out_tuser,
// the value read by a get hit in out_tdata. The cfg_* port sets the number of
// entries in use before the least recent one is evicted.
// A request runs through the scan, last, update and finish states: the tags
// are compared one entry per cycle through the single read port of the tag
// memory, whose read data is registered, then the update state writes the
// store and the finish state hands the result over. Only one request is in
// flight at a time.
// Reset empties the store and sets the limit to 16; no clearing pass is run.
// If the receiver stalls, the result is held in the output register and the
// block waits with the next result until that beat has been taken.
// ----------------------------------------------------------------------------
module lru_key_value_store_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // Fields from bit 0: key, new_value.
  input  logic [lkv_pkg::KEY_BITS+lkv_pkg::VALUE_BITS-1:0] in_tdata,
  // Fields from bit 0: opcode.
  input  logic                                    in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // Fields from bit 0: read_value.
  output logic [lkv_pkg::VALUE_BITS-1:0]          out_tdata,
  // Fields from bit 0: hit, evicted.
  output logic [1:0]                              out_tuser,
  input  logic                                    cfg_wr_en,
  input  logic [lkv_pkg::LIMIT_W-1:0]             cfg_wr_data
);

  import lkv_pkg::*;

  lkv_state_t state_r;

  logic [LIMIT_W-1:0]    entry_limit_r;
  logic [ENTRIES-1:0]    valid_r;
  logic [ENTRIES-1:0]    valid_nxt;
  logic [RANK_W-1:0]     rank_r   [ENTRIES];
  logic [RANK_W-1:0]     rank_nxt [ENTRIES];
  logic [CNT_W-1:0]      occ_r;

  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  logic [IDX_W-1:0]      scan_idx_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic                  cmp_vld_r;

  logic                  found_r;
  logic [IDX_W-1:0]      match_idx_r;
  logic [RANK_W-1:0]     match_rank_r;
  logic [VALUE_BITS-1:0] match_data_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic                  lru_any_r;
  logic [IDX_W-1:0]      lru_idx_r;
  logic [RANK_W-1:0]     lru_rank_r;

  logic                  res_hit_r;
  logic                  res_ev_r;
  logic [VALUE_BITS-1:0] res_data_r;
  logic                  out_hit_r;
  logic                  out_ev_r;
  logic [VALUE_BITS-1:0] out_data_r;
  logic                  out_tvalid_r;

  logic [KEY_BITS-1:0]   tag_q;
  logic [VALUE_BITS-1:0] data_q;

  logic                  in_fire;
  logic                  cmp_valid;
  logic [RANK_W-1:0]     cmp_rank;
  logic [CNT_W-1:0]      limit_eff;

  logic                  upd_en;
  logic [IDX_W-1:0]      upd_slot;
  logic [CNT_W-1:0]      upd_old;
  logic                  set_valid;
  logic                  wr_tag_en;
  logic                  wr_data_en;
  logic                  res_hit;
  logic                  res_ev;
  logic [VALUE_BITS-1:0] res_data;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_ev_r, out_hit_r};

  lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_tag_en),
    .wr_addr (upd_slot),
    .wr_data (key_r),
    .rd_addr (scan_idx_r),
    .rd_data (tag_q)
  );

  lkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_data_ram (
    .clk     (clk),
    .wr_en   (wr_data_en),
    .wr_addr (upd_slot),
    .wr_data (val_r),
    .rd_addr (scan_idx_r),
    .rd_data (data_q)
  );

  assign cmp_valid = valid_r[cmp_idx_r];
  assign cmp_rank  = rank_r[cmp_idx_r];

  always_comb begin
    if (entry_limit_r == '0) begin
      limit_eff = CNT_W'(1);
    end else if (CNT_W'(entry_limit_r) > CNT_W'(ENTRIES)) begin
      limit_eff = CNT_W'(ENTRIES);
    end else begin
      limit_eff = CNT_W'(entry_limit_r);
    end
  end

  always_comb begin
    upd_en     = 1'b0;
    upd_slot   = match_idx_r;
    upd_old    = CNT_W'(match_rank_r);
    set_valid  = 1'b0;
    wr_tag_en  = 1'b0;
    wr_data_en = 1'b0;
    res_hit    = 1'b0;
    res_ev     = 1'b0;
    res_data   = '0;
    if (state_r == ST_UPDATE) begin
      if (found_r) begin
        upd_en  = 1'b1;
        res_hit = 1'b1;
        if (op_r == OP_GET) begin
          res_data = match_data_r;
        end else begin
          wr_data_en = 1'b1;
        end
      end else if (op_r == OP_ADD) begin
        if (occ_r < limit_eff) begin
          if (free_found_r) begin
            upd_en     = 1'b1;
            upd_slot   = free_idx_r;
            upd_old    = occ_r + CNT_W'(1);
            set_valid  = 1'b1;
            wr_tag_en  = 1'b1;
            wr_data_en = 1'b1;
          end
        end else if (lru_any_r) begin
          upd_en     = 1'b1;
          upd_slot   = lru_idx_r;
          upd_old    = CNT_W'(lru_rank_r);
          wr_tag_en  = 1'b1;
          wr_data_en = 1'b1;
          res_ev     = 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (upd_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && (IDX_W'(i) != upd_slot) && (CNT_W'(rank_r[i]) < upd_old)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
      rank_nxt[upd_slot] = '0;
      if (set_valid) begin
        valid_nxt[upd_slot] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_limit_r <= LIMIT_W'(LIMIT_RESET);
      valid_r       <= '0;
      occ_r         <= '0;
      cmp_vld_r     <= 1'b0;
      scan_idx_r    <= '0;
      out_tvalid_r  <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        entry_limit_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      if (set_valid) begin
        occ_r <= occ_r + CNT_W'(1);
      end
      cmp_vld_r <= (state_r == ST_SCAN);
      if ((state_r == ST_FINISH) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          scan_idx_r <= '0;
          if (in_fire) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
          if (scan_idx_r == IDX_W'(ENTRIES - 1)) begin
            state_r <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_tvalid_r || out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
    if (in_fire) begin
      op_r         <= in_tuser;
      key_r        <= in_tdata[KEY_BITS-1:0];
      val_r        <= in_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      lru_any_r    <= 1'b0;
    end else if (cmp_vld_r) begin
      if (cmp_valid && (tag_q == key_r) && !found_r) begin
        found_r      <= 1'b1;
        match_idx_r  <= cmp_idx_r;
        match_rank_r <= cmp_rank;
        match_data_r <= data_q;
      end
      if (!cmp_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
      if (cmp_valid && (!lru_any_r || (cmp_rank > lru_rank_r))) begin
        lru_any_r  <= 1'b1;
        lru_idx_r  <= cmp_idx_r;
        lru_rank_r <= cmp_rank;
      end
    end
    if (state_r == ST_UPDATE) begin
      res_hit_r  <= res_hit;
      res_ev_r   <= res_ev;
      res_data_r <= res_data;
    end
    if ((state_r == ST_FINISH) && (!out_tvalid_r || out_tready)) begin
      out_hit_r  <= res_hit_r;
      out_ev_r   <= res_ev_r;
      out_data_r <= res_data_r;
    end
  end

endmodule

FILE: verif/lru_key_value_store_unit_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_store_unit_tb: self-checking bench for the LRU key-value store
// Sends get and add requests over the input stream and compares every result
// beat with a cycle-free model of the store kept inside the bench. Directed
// cases cover empty, full and overwritten entries and the limit extremes;
// random phases follow under several limits and idling patterns.
// ----------------------------------------------------------------------------
module lru_key_value_store_unit_tb;
  import lkv_pkg::*;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
  } lookup_result_t;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [KEY_BITS+VALUE_BITS-1:0] in_tdata    = '0;
  logic                           in_tuser    = OP_GET;
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [VALUE_BITS-1:0]          out_tdata;
  logic [1:0]                     out_tuser;
  logic                           cfg_wr_en   = 1'b0;
  logic [LIMIT_W-1:0]             cfg_wr_data = '0;

  logic [KEY_BITS-1:0]   store_tag   [ENTRIES];
  logic [VALUE_BITS-1:0] store_data  [ENTRIES];
  bit                    store_valid [ENTRIES];
  int unsigned           store_rank  [ENTRIES];
  int unsigned           store_count;
  logic [LIMIT_W-1:0]    store_limit;

  lookup_result_t expected_results[$];
  int             failures   = 0;
  int             idle_pct   = 0;
  int             stall_pct  = 0;

  lru_key_value_store_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_store();
    for (int i = 0; i < ENTRIES; i++) begin
      store_tag[i]   = '0;
      store_data[i]  = '0;
      store_valid[i] = 1'b0;
      store_rank[i]  = 0;
    end
    store_count = 0;
    store_limit = LIMIT_W'(LIMIT_RESET);
  endfunction

  function automatic void make_most_recent(int s, int unsigned old_rank);
    for (int i = 0; i < ENTRIES; i++) begin
      if (store_valid[i] && i != s && store_rank[i] < old_rank) store_rank[i]++;
    end
    store_rank[s] = 0;
  endfunction

  function automatic lookup_result_t predict_request(input logic op,
                                                     input logic [KEY_BITS-1:0] k,
                                                     input logic [VALUE_BITS-1:0] v);
    int unsigned    lim;
    int             slot;
    int             worst;
    bit             found;
    lookup_result_t r;
    lim   = (store_limit == 0) ? 1 : ((store_limit > ENTRIES) ? ENTRIES : store_limit);
    r     = '0;
    slot  = 0;
    worst = -1;
    found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && store_valid[i] && store_tag[i] == k) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (op == OP_GET) r.read_value = store_data[slot];
      else store_data[slot] = v;
      make_most_recent(slot, store_rank[slot]);
    end else if (op == OP_ADD) begin
      if (store_count < lim) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && !store_valid[i]) begin
            found = 1'b1;
            slot  = i;
          end
        end
        store_valid[slot] = 1'b1;
        store_tag[slot]   = k;
        store_data[slot]  = v;
        store_count++;
        make_most_recent(slot, store_count);
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (store_valid[i] && int'(store_rank[i]) > worst) begin
            worst = store_rank[i];
            slot  = i;
          end
        end
        store_tag[slot]  = k;
        store_data[slot] = v;
        make_most_recent(slot, worst);
        r.evicted = 1'b1;
      end
    end
    return r;
  endfunction

  // The receiver side: random back-pressure and the check of each result beat.
  always @(posedge clk) begin
    lookup_result_t want;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat: hit %b value %h evicted %b",
                 $time, out_tuser[0], out_tdata, out_tuser[1]);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser[0] !== want.hit) begin
          $display("%0t: hit mismatch: expected %b, actual %b", $time, want.hit, out_tuser[0]);
          failures++;
        end
        if (out_tdata !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %h, actual %h",
                   $time, want.read_value, out_tdata);
          failures++;
        end
        if (out_tuser[1] !== want.evicted) begin
          $display("%0t: evicted mismatch: expected %b, actual %b",
                   $time, want.evicted, out_tuser[1]);
          failures++;
        end
      end
    end
  end

  task automatic send_request(input logic op, input logic [KEY_BITS-1:0] k,
                              input logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {v, k};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_request(op, k, v));
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic set_entry_limit(input logic [LIMIT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    store_limit = value;
  endtask

  task automatic test_get_and_update();
    send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_ADD, 32'h0000_0000, 32'h5A5A_A5A5);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h1234_5678, 32'h0000_0000);
  endtask

  task automatic test_lru_replacement();
    wait_for_results();
    set_entry_limit(5'd3);
    send_request(OP_ADD, 32'h0000_0001, 32'h0000_0001);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_ADD, 32'h0000_0002, 32'h0000_0002);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
  endtask

  task automatic test_limit_extremes();
    // A limit of zero behaves as one and lies below the current occupancy.
    wait_for_results();
    set_entry_limit(5'd0);
    send_request(OP_ADD, 32'h0000_0003, 32'h0000_0003);
    send_request(OP_GET, 32'h0000_0003, 32'h0000_0000);
    send_request(OP_ADD, 32'h0000_0003, 32'h0000_0033);
    wait_for_results();
    set_entry_limit(5'd31);
    send_request(OP_ADD, 32'h0000_0004, 32'h0000_0004);
    send_request(OP_GET, 32'h0000_0002, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    logic [KEY_BITS-1:0] key_pool [24];
    logic [KEY_BITS-1:0] k;
    logic [LIMIT_W-1:0]  lim;
    int                  pool_size;
    for (int phase = 0; phase < 8; phase++) begin
      wait_for_results();
      case (phase)
        0: lim = 5'd16;
        1: lim = 5'd1;
        2: lim = 5'd5;
        3: lim = 5'd31;
        4: lim = 5'd0;
        5: lim = 5'd17;
        6: lim = LIMIT_W'($urandom_range(31));
        default: lim = 5'd2;
      endcase
      set_entry_limit(lim);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (int i = 0; i < 24; i++) key_pool[i] = $urandom();
      key_pool[0] = '0;
      key_pool[1] = '1;
      pool_size = $urandom_range(2, 24);
      for (int n = 0; n < 190; n++) begin
        if ($urandom_range(99) == 0) wait_for_results();
        if ($urandom_range(9) == 0) k = $urandom();
        else k = key_pool[$urandom_range(pool_size - 1)];
        send_request(($urandom_range(99) < 55) ? OP_ADD : OP_GET, k, $urandom());
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    clear_store();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_get_and_update();
    test_lru_replacement();
    test_limit_extremes();
    test_random_traffic();
    wait_for_results();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
